FILE: design/three_lfsr_filter_keystream_unit_assert.svh
// Assertion macros for the three-LFSR keystream unit.
// Depends on nothing; included by the top level.
`ifndef THREE_LFSR_FILTER_KEYSTREAM_UNIT_ASSERT_SVH
`define THREE_LFSR_FILTER_KEYSTREAM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLFK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlfk assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLFK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlfk assertion failed");

`endif

FILE: design/tlfk_pkg.sv
// Shared types and constants of the three-LFSR keystream unit.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tlfk_pkg;

    localparam int NUM_TAPS   = 7;
    localparam int TAP_W      = 5;
    localparam int TAPS_W     = NUM_TAPS * TAP_W;
    localparam int SPAN_W     = 2 ** TAP_W;
    localparam int CFG_DATA_W = 35;
    localparam int CFG_ADDR_W = 3;

    typedef logic [TAPS_W-1:0] taps_t;

    typedef enum logic {
        CMD_STEP = 1'b0,
        CMD_LOAD = 1'b1
    } command_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FB_MASK_A = 3'd0,
        CFG_FB_MASK_B = 3'd1,
        CFG_FB_MASK_C = 3'd2,
        CFG_TAPS_A    = 3'd3,
        CFG_TAPS_B    = 3'd4,
        CFG_TAPS_C    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic load;
        logic step;
    } lfsr_ctrl_t;

endpackage

`default_nettype wire

FILE: design/tlfk_filter.sv
// Fixed degree-4 Boolean filter over seven tapped state bits.
// Depends on tlfk_pkg for the tap count.
`default_nettype none

module tlfk_filter (
    input  wire logic [tlfk_pkg::NUM_TAPS-1:0] x,
    output logic                               filt_bit
);

    logic r0, r1, r2, r3, r4;

    always_comb begin
        r0 = (x[0] & x[2] & x[5] & x[6]) ^ (x[0] & x[3] & x[5] & x[6])
           ^ (x[0] & x[1] & x[5] & x[6]) ^ (x[0] & x[2] & x[3] & x[6])
           ^ (x[1] & x[3] & x[4] & x[6]);
        r1 = (x[1] & x[3] & x[5] & x[6]) ^ (x[0] & x[2] & x[4]) ^ (x[0] & x[2] & x[3])
           ^ (x[0] & x[1] & x[3]) ^ (x[0] & x[2] & x[6]) ^ (x[0] & x[1] & x[4]);
        r2 = (x[0] & x[1] & x[6]) ^ (x[1] & x[2] & x[6]) ^ (x[2] & x[5] & x[6])
           ^ (x[0] & x[3] & x[5]) ^ (x[1] & x[4] & x[6]) ^ (x[1] & x[2] & x[5]);
        r3 = (x[0] & x[3]) ^ (x[0] & x[5]) ^ (x[1] & x[3]) ^ (x[1] & x[5])
           ^ (x[1] & x[6]) ^ (x[0] & x[2]) ^ x[1] ^ (x[2] & x[3])
           ^ (x[2] & x[5]) ^ (x[2] & x[6]);
        r4 = (x[4] & x[5]) ^ (x[5] & x[6]) ^ x[2] ^ x[3] ^ x[5];
        filt_bit = r0 ^ r1 ^ r2 ^ r3 ^ r4;
    end

endmodule

`default_nettype wire

FILE: design/tlfk_lfsr.sv
// One Fibonacci LFSR with programmable feedback mask and seven filter taps.
// Depends on tlfk_pkg and tlfk_filter.
`default_nettype none

module tlfk_lfsr #(
    parameter int LEN = 25
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tlfk_pkg::lfsr_ctrl_t ctrl,
    input  wire logic [LEN-1:0]       seed,
    input  wire logic [LEN-1:0]       fb_mask,
    input  wire tlfk_pkg::taps_t      taps,
    output logic                      filt_bit
);

    logic [LEN-1:0]                    state_reg;
    logic [LEN-1:0]                    state_next;
    logic [tlfk_pkg::SPAN_W-1:0]       state_ext;
    logic [tlfk_pkg::NUM_TAPS-1:0]     tap_bits;

    // Bits above LEN read as zero, so positions beyond the length yield zero.
    assign state_ext = tlfk_pkg::SPAN_W'(state_reg);

    always_comb begin
        for (int k = 0; k < tlfk_pkg::NUM_TAPS; k++) begin
            tap_bits[k] = state_ext[taps[k*tlfk_pkg::TAP_W +: tlfk_pkg::TAP_W]];
        end
    end

    always_comb begin
        state_next = state_reg;
        if (ctrl.load) begin
            state_next = seed;
        end else if (ctrl.step) begin
            state_next = {^(state_reg & fb_mask), state_reg[LEN-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LEN'(1);
        end else begin
            state_reg <= state_next;
        end
    end

    tlfk_filter u_filter (
        .x        (tap_bits),
        .filt_bit (filt_bit)
    );

endmodule

`default_nettype wire

FILE: design/three_lfsr_filter_keystream_unit.sv
// A step transaction's key bit is registered and valid in the cycle after acceptance.
// Throughput: one transaction per cycle while the output is not stalled; the three state
// registers update in the accepting cycle, so the next step sees the advanced states at once.
// A load transaction replaces the states and produces no result.
// Synchronous active-low reset sets all states to one and the registers to
// their defaults; the block accepts transactions in the first cycle after it.
`default_nettype none

`include "three_lfsr_filter_keystream_unit_assert.svh"

module three_lfsr_filter_keystream_unit #(
    parameter int LEN_A = 25,
    parameter int LEN_B = 18,
    parameter int LEN_C = 19
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [LEN_A-1:0]                  s_seed_a,
    input  wire logic [LEN_B-1:0]                  s_seed_b,
    input  wire logic [LEN_C-1:0]                  s_seed_c,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_key_bit,
    input  wire logic                              cfg_we,
    input  wire logic [tlfk_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tlfk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [LEN_A-1:0]     fb_mask_a_reg, fb_mask_a_next;
    logic [LEN_B-1:0]     fb_mask_b_reg, fb_mask_b_next;
    logic [LEN_C-1:0]     fb_mask_c_reg, fb_mask_c_next;
    tlfk_pkg::taps_t      taps_a_reg, taps_a_next;
    tlfk_pkg::taps_t      taps_b_reg, taps_b_next;
    tlfk_pkg::taps_t      taps_c_reg, taps_c_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_key_bit_reg, m_key_bit_next;

    logic                 in_accept;
    logic                 is_load;
    tlfk_pkg::lfsr_ctrl_t lfsr_ctrl;
    logic                 filt_a, filt_b, filt_c;
    logic                 key_bit;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign is_load   = (s_command == tlfk_pkg::CMD_LOAD);

    assign lfsr_ctrl = '{load: in_accept && is_load, step: in_accept && !is_load};

    assign key_bit   = filt_a ^ filt_b ^ filt_c;
    assign m_valid   = m_valid_reg;
    assign m_key_bit = m_key_bit_reg;

    always_comb begin
        fb_mask_a_next = fb_mask_a_reg;
        fb_mask_b_next = fb_mask_b_reg;
        fb_mask_c_next = fb_mask_c_reg;
        taps_a_next    = taps_a_reg;
        taps_b_next    = taps_b_reg;
        taps_c_next    = taps_c_reg;
        if (cfg_we) begin
            unique case (tlfk_pkg::cfg_index_t'(cfg_addr))
                tlfk_pkg::CFG_FB_MASK_A: fb_mask_a_next = cfg_wdata[LEN_A-1:0];
                tlfk_pkg::CFG_FB_MASK_B: fb_mask_b_next = cfg_wdata[LEN_B-1:0];
                tlfk_pkg::CFG_FB_MASK_C: fb_mask_c_next = cfg_wdata[LEN_C-1:0];
                tlfk_pkg::CFG_TAPS_A:    taps_a_next    = cfg_wdata[tlfk_pkg::TAPS_W-1:0];
                tlfk_pkg::CFG_TAPS_B:    taps_b_next    = cfg_wdata[tlfk_pkg::TAPS_W-1:0];
                tlfk_pkg::CFG_TAPS_C:    taps_c_next    = cfg_wdata[tlfk_pkg::TAPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_key_bit_next = m_key_bit_reg;
        if (lfsr_ctrl.step) begin
            m_valid_next   = 1'b1;
            m_key_bit_next = key_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_mask_a_reg <= LEN_A'(255);
            fb_mask_b_reg <= '0;
            fb_mask_c_reg <= LEN_C'(267289);
            taps_a_reg    <= '0;
            taps_b_reg    <= '0;
            taps_c_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            fb_mask_a_reg <= fb_mask_a_next;
            fb_mask_b_reg <= fb_mask_b_next;
            fb_mask_c_reg <= fb_mask_c_next;
            taps_a_reg    <= taps_a_next;
            taps_b_reg    <= taps_b_next;
            taps_c_reg    <= taps_c_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_key_bit_reg <= m_key_bit_next;
    end

    tlfk_lfsr #(.LEN(LEN_A)) u_lfsr_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lfsr_ctrl),
        .seed     (s_seed_a),
        .fb_mask  (fb_mask_a_reg),
        .taps     (taps_a_reg),
        .filt_bit (filt_a)
    );

    tlfk_lfsr #(.LEN(LEN_B)) u_lfsr_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lfsr_ctrl),
        .seed     (s_seed_b),
        .fb_mask  (fb_mask_b_reg),
        .taps     (taps_b_reg),
        .filt_bit (filt_b)
    );

    tlfk_lfsr #(.LEN(LEN_C)) u_lfsr_c (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lfsr_ctrl),
        .seed     (s_seed_c),
        .fb_mask  (fb_mask_c_reg),
        .taps     (taps_c_reg),
        .filt_bit (filt_c)
    );

    `TLFK_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, lfsr_ctrl.step, m_valid)
    `TLFK_ASSERT_NEXT(a_load_gives_none, aclk, aresetn, lfsr_ctrl.load, !m_valid)
    `TLFK_ASSERT_NOW(a_no_overrun, aclk, aresetn, m_valid && !m_ready, !s_ready)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the three-LFSR filtered keystream unit.
// It predicts every key bit from its own model of the three registers and checks each result.
// Depends on tlfk_pkg and three_lfsr_filter_keystream_unit.
`default_nettype none

module tb_top;

    localparam int LEN_A = 25;
    localparam int LEN_B = 18;
    localparam int LEN_C = 19;
    localparam int NUM_TAPS = tlfk_pkg::NUM_TAPS;
    localparam int TAP_W = tlfk_pkg::TAP_W;
    localparam int SPAN_W = tlfk_pkg::SPAN_W;
    localparam int CFG_ADDR_W = tlfk_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = tlfk_pkg::CFG_DATA_W;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tlfk_pkg::command_t s_command = tlfk_pkg::CMD_STEP;
    logic [LEN_A-1:0] s_seed_a = '0;
    logic [LEN_B-1:0] s_seed_b = '0;
    logic [LEN_C-1:0] s_seed_c = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_key_bit;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    three_lfsr_filter_keystream_unit #(
        .LEN_A(LEN_A),
        .LEN_B(LEN_B),
        .LEN_C(LEN_C)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_seed_a(s_seed_a),
        .s_seed_b(s_seed_b),
        .s_seed_c(s_seed_c),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_key_bit(m_key_bit),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the generator state and its programmable registers.
    bit [31:0] lfsr_a = 1, lfsr_b = 1, lfsr_c = 1;
    bit [34:0] fb_mask_a = 255, fb_mask_b = 0, fb_mask_c = 267289;
    bit [34:0] taps_a = 0, taps_b = 0, taps_c = 0;

    bit key_bit_q[$];
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int errors = 0;
    int n_steps = 0;
    int n_loads = 0;
    int n_keys = 0;
    int n_cfg = 0;
    int quiet_cycles = 0;

    function automatic bit [31:0] lfsr_shift(bit [31:0] s, bit [34:0] mask, int len);
        bit [31:0] keep;
        bit fb;
        keep = (32'd1 << len) - 32'd1;
        fb = ^(s & mask[31:0] & keep);
        return ((s & keep) >> 1) | ({31'd0, fb} << (len - 1));
    endfunction

    function automatic bit filter_out(bit [31:0] s, bit [34:0] taps);
        bit [6:0] x;
        bit r0, r1, r2, r3, r4;
        for (int k = 0; k < NUM_TAPS; k++) begin
            x[k] = s[taps[TAP_W*k +: TAP_W]];
        end
        r0 = (x[0]&x[2]&x[5]&x[6]) ^ (x[0]&x[3]&x[5]&x[6]) ^ (x[0]&x[1]&x[5]&x[6])
           ^ (x[0]&x[2]&x[3]&x[6]) ^ (x[1]&x[3]&x[4]&x[6]);
        r1 = (x[1]&x[3]&x[5]&x[6]) ^ (x[0]&x[2]&x[4]) ^ (x[0]&x[2]&x[3])
           ^ (x[0]&x[1]&x[3]) ^ (x[0]&x[2]&x[6]) ^ (x[0]&x[1]&x[4]);
        r2 = (x[0]&x[1]&x[6]) ^ (x[1]&x[2]&x[6]) ^ (x[2]&x[5]&x[6])
           ^ (x[0]&x[3]&x[5]) ^ (x[1]&x[4]&x[6]) ^ (x[1]&x[2]&x[5]);
        r3 = (x[0]&x[3]) ^ (x[0]&x[5]) ^ (x[1]&x[3]) ^ (x[1]&x[5]) ^ (x[1]&x[6])
           ^ (x[0]&x[2]) ^ x[1] ^ (x[2]&x[3]) ^ (x[2]&x[5]) ^ (x[2]&x[6]);
        r4 = (x[4]&x[5]) ^ (x[5]&x[6]) ^ x[2] ^ x[3] ^ x[5];
        return r0 ^ r1 ^ r2 ^ r3 ^ r4;
    endfunction

    function automatic bit predict_key_bit();
        bit k;
        k = filter_out(lfsr_a, taps_a) ^ filter_out(lfsr_b, taps_b)
          ^ filter_out(lfsr_c, taps_c);
        lfsr_a = lfsr_shift(lfsr_a, fb_mask_a, LEN_A);
        lfsr_b = lfsr_shift(lfsr_b, fb_mask_b, LEN_B);
        lfsr_c = lfsr_shift(lfsr_c, fb_mask_c, LEN_C);
        return k;
    endfunction

    // Expectations are queued before results are checked, so ordering holds at any latency.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_command == tlfk_pkg::CMD_LOAD) begin
                    lfsr_a = 32'(s_seed_a);
                    lfsr_b = 32'(s_seed_b);
                    lfsr_c = 32'(s_seed_c);
                    n_loads++;
                end else begin
                    key_bit_q.push_back(predict_key_bit());
                    n_steps++;
                end
            end
            if (m_valid && m_ready) begin
                n_keys++;
                if (key_bit_q.size() == 0) begin
                    $display("%0t: unexpected key bit transaction, expected none, actual %0b",
                             $time, m_key_bit);
                    errors++;
                end else if (key_bit_q[0] !== m_key_bit) begin
                    $display("%0t: key_bit mismatch, expected %0b, actual %0b",
                             $time, key_bit_q[0], m_key_bit);
                    errors++;
                    void'(key_bit_q.pop_front());
                end else begin
                    void'(key_bit_q.pop_front());
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(tlfk_pkg::command_t cmd, bit [LEN_A-1:0] sa,
                             bit [LEN_B-1:0] sb, bit [LEN_C-1:0] sc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_command = cmd;
        s_seed_a = sa;
        s_seed_b = sb;
        s_seed_c = sc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_step();
        send_item(tlfk_pkg::CMD_STEP, LEN_A'($urandom), LEN_B'($urandom), LEN_C'($urandom));
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (key_bit_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        n_cfg++;
        case (idx)
            tlfk_pkg::CFG_FB_MASK_A: fb_mask_a = value & ((35'd1 << LEN_A) - 35'd1);
            tlfk_pkg::CFG_FB_MASK_B: fb_mask_b = value & ((35'd1 << LEN_B) - 35'd1);
            tlfk_pkg::CFG_FB_MASK_C: fb_mask_c = value & ((35'd1 << LEN_C) - 35'd1);
            tlfk_pkg::CFG_TAPS_A: taps_a = value;
            tlfk_pkg::CFG_TAPS_B: taps_b = value;
            tlfk_pkg::CFG_TAPS_C: taps_c = value;
            default: ;
        endcase
    endtask

    function automatic bit [34:0] same_taps(int pos);
        bit [34:0] t;
        t = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            t[TAP_W*k +: TAP_W] = TAP_W'(pos);
        end
        return t;
    endfunction

    function automatic bit [34:0] random_taps(int len);
        bit [34:0] t;
        for (int k = 0; k < NUM_TAPS; k++) begin
            if ($urandom_range(99) < 80) begin
                t[TAP_W*k +: TAP_W] = TAP_W'($urandom_range(len - 1));
            end else begin
                t[TAP_W*k +: TAP_W] = TAP_W'($urandom_range(SPAN_W - 1));
            end
        end
        return t;
    endfunction

    function automatic bit [34:0] random_word();
        return 35'({$urandom, $urandom});
    endfunction

    task automatic configure(bit [34:0] ma, bit [34:0] mb, bit [34:0] mc,
                             bit [34:0] ta, bit [34:0] tb, bit [34:0] tc);
        drain_results();
        cfg_write(tlfk_pkg::CFG_FB_MASK_A, ma);
        cfg_write(tlfk_pkg::CFG_FB_MASK_B, mb);
        cfg_write(tlfk_pkg::CFG_FB_MASK_C, mc);
        cfg_write(tlfk_pkg::CFG_TAPS_A, ta);
        cfg_write(tlfk_pkg::CFG_TAPS_B, tb);
        cfg_write(tlfk_pkg::CFG_TAPS_C, tc);
    endtask

    task automatic test_reset_defaults();
        repeat (3) send_step();
    endtask

    task automatic test_spare_register_writes();
        drain_results();
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '1);
        send_step();
    endtask

    task automatic test_directed_extremes();
        configure('1, '1, '1, same_taps(SPAN_W - 1), same_taps(SPAN_W - 1),
                  same_taps(SPAN_W - 1));
        send_item(tlfk_pkg::CMD_LOAD, '1, '1, '1);
        repeat (2) send_step();
        configure('1, '1, '1, same_taps(LEN_A - 1), same_taps(LEN_B - 1),
                  same_taps(LEN_C - 1));
        send_item(tlfk_pkg::CMD_LOAD, '1, '1, '1);
        repeat (3) send_step();
        send_item(tlfk_pkg::CMD_LOAD, '0, '0, '0);
        repeat (2) send_step();
        configure('0, '0, '0, 35'h18a418820, 35'h18a418820, 35'h18a418820);
        send_item(tlfk_pkg::CMD_LOAD, '1, 18'h2aaaa, 19'h55555);
        repeat (3) send_step();
        configure(35'h0000000ff, 35'h000020021, 267289, '0, random_taps(LEN_B), '0);
        send_item(tlfk_pkg::CMD_LOAD, 25'h1, 18'h20000, 19'h40000);
        repeat (3) send_step();
    endtask

    task automatic run_segment(int kind, int count);
        case (kind)
            1: configure('1, '1, '1, same_taps(SPAN_W - 1), '1, same_taps(LEN_C - 1));
            2: configure('0, '0, '0, '0, '0, '0);
            default: configure(random_word(), random_word(), random_word(),
                               random_taps(LEN_A), random_taps(LEN_B), random_taps(LEN_C));
        endcase
        send_item(tlfk_pkg::CMD_LOAD, LEN_A'($urandom), LEN_B'($urandom), LEN_C'($urandom));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 2) begin
                drain_results();
            end
            if ($urandom_range(99) < 10) begin
                send_item(tlfk_pkg::CMD_LOAD,
                          ($urandom_range(19) == 0) ? '0 : LEN_A'($urandom),
                          ($urandom_range(19) == 0) ? '0 : LEN_B'($urandom),
                          ($urandom_range(19) == 0) ? '0 : LEN_C'($urandom));
            end else begin
                send_step();
            end
        end
    endtask

    task automatic test_random_traffic();
        int src_pct[4];
        int sink_pct[4];
        src_pct = '{0, 61, 0, 32};
        sink_pct = '{0, 0, 61, 32};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            run_segment((2 * p) % 4, 61);
            run_segment((2 * p + 1) % 4, 61);
            drain_results();
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_spare_register_writes();
        test_directed_extremes();
        test_random_traffic();
        drain_results();
        repeat (10) @(negedge aclk);
        $display("Covered %0d step and %0d load transactions, %0d key bits checked,",
                 n_steps, n_loads, n_keys);
        $display("%0d register writes across four flow-control phases.", n_cfg);
        if (errors == 0 && key_bit_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d key bits never arrived", errors, key_bit_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
